### rtl/assert_macros.svh
// Assertion helpers shared by the RTL of the complex arithmetic unit.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CNA_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("complex alu assertion failed");

// Next-cycle implication, checked outside reset.
`define CNA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("complex alu assertion failed");

`endif

### rtl/cnalu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cnalu_pkg;

  // Operand and result widths in signed Q16.16.
  localparam int DW = 32;
  localparam int FB = 16;
  localparam int PW = 2 * DW;
  localparam int WW = PW + 2;
  localparam int FIFO_DEPTH = 4;

  // Operation codes on the input channel.
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_SQR = 3'd4;
  localparam logic [2:0] CMD_MOD = 3'd5;

  localparam logic [DW-1:0] SMAX_V = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SMIN_V = {1'b1, {(DW-1){1'b0}}};

  // Operation class after decode. Square is a multiply with B taken from A.
  typedef enum logic [5:0] {
    OP_NONE = 6'b000001,
    OP_ADD  = 6'b000010,
    OP_SUB  = 6'b000100,
    OP_MUL  = 6'b001000,
    OP_DIV  = 6'b010000,
    OP_MOD  = 6'b100000
  } op_t;

  // Decoded item passed from the front end through the queue.
  typedef struct packed {
    op_t           op;
    logic          dz;
    logic [DW-1:0] a_re;
    logic [DW-1:0] a_im;
    logic [DW-1:0] b_re;
    logic [DW-1:0] b_im;
  } item_t;

  // State carried through the divider and square root iterations.
  typedef struct packed {
    op_t           op;
    logic          dz;
    logic [DW-1:0] rr;
    logic [DW-1:0] ri;
    logic          neg_re;
    logic          neg_im;
    logic          ovf_re;
    logic          ovf_im;
    logic [PW-1:0] den;
    logic [PW-1:0] drem_re;
    logic [PW-1:0] drem_im;
    logic [DW-1:0] dlo_re;
    logic [DW-1:0] dlo_im;
    logic [DW-1:0] q_re;
    logic [DW-1:0] q_im;
    logic [DW+1:0] srem;
    logic [PW-1:0] sn;
    logic [DW-1:0] sroot;
  } iter_t;

  // Sign-extend a product to the working width.
  function automatic logic signed [WW-1:0] ext_p(input logic [PW-1:0] v);
    ext_p = $signed({{(WW-PW){v[PW-1]}}, v});
  endfunction

  // Sign-extend an operand to the working width.
  function automatic logic signed [WW-1:0] ext_d(input logic [DW-1:0] v);
    ext_d = $signed({{(WW-DW){v[DW-1]}}, v});
  endfunction

  // Saturate a working-width value to the signed data range.
  function automatic logic [DW-1:0] sat(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] hi;
    logic signed [WW-1:0] lo;
    hi = $signed({{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}});
    lo = $signed({{(WW-DW+1){1'b1}}, {(DW-1){1'b0}}});
    if (v > hi) begin
      sat = SMAX_V;
    end else if (v < lo) begin
      sat = SMIN_V;
    end else begin
      sat = v[DW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/cnalu_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cnalu_fifo #(
  parameter int DEPTH = cnalu_pkg::FIFO_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  cnalu_pkg::item_t     push_data,
  output logic                 full,
  input  wire                  pop,
  output logic                 avail,
  output cnalu_pkg::item_t     pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cnalu_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign avail    = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `CNA_ASSERT_IMPL(a_fifo_no_overflow, push, !full)
  `CNA_ASSERT_IMPL(a_fifo_no_underflow, pop, cnt_r != '0)

endmodule

`default_nettype wire

### rtl/cnalu_front.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cnalu_front (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire  [2:0]                 in_cmd,
  input  wire  [cnalu_pkg::DW-1:0]   in_a_re,
  input  wire  [cnalu_pkg::DW-1:0]   in_a_im,
  input  wire  [cnalu_pkg::DW-1:0]   in_b_re,
  input  wire  [cnalu_pkg::DW-1:0]   in_b_im,
  output logic                       push,
  output cnalu_pkg::item_t           push_data,
  input  wire                        full
);

  logic             front_valid_r, front_valid_nxt;
  cnalu_pkg::item_t front_r;
  cnalu_pkg::item_t dec;
  logic             in_xfer;

  // Decode the command and pick the second operand.
  always_comb begin
    dec.op   = cnalu_pkg::OP_NONE;
    dec.dz   = 1'b0;
    dec.a_re = in_a_re;
    dec.a_im = in_a_im;
    dec.b_re = in_b_re;
    dec.b_im = in_b_im;
    unique case (in_cmd)
      cnalu_pkg::CMD_ADD: dec.op = cnalu_pkg::OP_ADD;
      cnalu_pkg::CMD_SUB: dec.op = cnalu_pkg::OP_SUB;
      cnalu_pkg::CMD_MUL: dec.op = cnalu_pkg::OP_MUL;
      cnalu_pkg::CMD_DIV: begin
        dec.op = cnalu_pkg::OP_DIV;
        dec.dz = (in_b_re == '0) && (in_b_im == '0);
      end
      cnalu_pkg::CMD_SQR: begin
        dec.op   = cnalu_pkg::OP_MUL;
        dec.b_re = in_a_re;
        dec.b_im = in_a_im;
      end
      cnalu_pkg::CMD_MOD: begin
        dec.op   = cnalu_pkg::OP_MOD;
        dec.b_re = in_a_re;
        dec.b_im = in_a_im;
      end
      default: dec.op = cnalu_pkg::OP_NONE;
    endcase
  end

  // The holding register moves into the queue whenever there is room.
  assign push      = front_valid_r && !full;
  assign push_data = front_r;
  assign in_stall  = front_valid_r && full;
  assign in_xfer   = in_valid && !in_stall;

  always_comb begin
    front_valid_nxt = in_xfer || (front_valid_r && !push);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      front_r <= dec;
    end
  end

  `CNA_ASSERT_NEXT(a_front_hold, front_valid_r && !push, front_valid_r)

endmodule

`default_nettype wire

### rtl/cnalu_step.sv
`timescale 1ns / 1ps
`default_nettype none

module cnalu_step (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 en,
  input  wire                 in_v,
  input  cnalu_pkg::iter_t    in_d,
  output logic                out_v,
  output cnalu_pkg::iter_t    out_d
);

  localparam int DW = cnalu_pkg::DW;
  localparam int PW = cnalu_pkg::PW;

  logic             v_r;
  cnalu_pkg::iter_t d_r, d_nxt;

  logic [PW:0]   t_re, t_im, dd, df_re, df_im;
  logic          ge_re, ge_im;
  logic [DW+3:0] st, trial, sdiff;
  logic          sge;

  // One restoring division bit for each part and one root bit.
  always_comb begin
    d_nxt = in_d;
    dd    = {1'b0, in_d.den};

    t_re  = {in_d.drem_re, in_d.dlo_re[DW-1]};
    ge_re = (t_re >= dd);
    df_re = t_re - dd;
    d_nxt.drem_re = ge_re ? df_re[PW-1:0] : t_re[PW-1:0];
    d_nxt.q_re    = {in_d.q_re[DW-2:0], ge_re};
    d_nxt.dlo_re  = {in_d.dlo_re[DW-2:0], 1'b0};

    t_im  = {in_d.drem_im, in_d.dlo_im[DW-1]};
    ge_im = (t_im >= dd);
    df_im = t_im - dd;
    d_nxt.drem_im = ge_im ? df_im[PW-1:0] : t_im[PW-1:0];
    d_nxt.q_im    = {in_d.q_im[DW-2:0], ge_im};
    d_nxt.dlo_im  = {in_d.dlo_im[DW-2:0], 1'b0};

    st    = {in_d.srem, in_d.sn[PW-1:PW-2]};
    trial = {2'b00, in_d.sroot, 2'b01};
    sge   = (st >= trial);
    sdiff = st - trial;
    d_nxt.srem  = sge ? sdiff[DW+1:0] : st[DW+1:0];
    d_nxt.sroot = {in_d.sroot[DW-2:0], sge};
    d_nxt.sn    = {in_d.sn[PW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_v = v_r;
  assign out_d = d_r;

endmodule

`default_nettype wire

### rtl/cnalu_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cnalu_back (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        q_avail,
  input  cnalu_pkg::item_t           q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [cnalu_pkg::DW-1:0]   out_res_re,
  output logic [cnalu_pkg::DW-1:0]   out_res_im,
  output logic [cnalu_pkg::DW-1:0]   out_magnitude,
  output logic                       out_div_by_zero
);

  localparam int DW    = cnalu_pkg::DW;
  localparam int FB    = cnalu_pkg::FB;
  localparam int PW    = cnalu_pkg::PW;
  localparam int WW    = cnalu_pkg::WW;
  localparam int STEPS = DW;
  localparam int SH    = DW - FB;

  logic en;

  // Stage 1: products, squares of the denominator, add, subtract, conjugate.
  logic            s1_v_r;
  cnalu_pkg::op_t  s1_op_r;
  logic            s1_dz_r;
  logic [PW-1:0]   s1_p_rr_r, s1_p_ii_r, s1_p_ri_r, s1_p_ir_r, s1_sq_r_r, s1_sq_i_r;
  logic [DW-1:0]   s1_rr_r, s1_ri_r;
  logic [PW-1:0]   p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;
  logic [DW-1:0]   s1_rr_nxt, s1_ri_nxt;

  // Stage 2: pair sums and divider operands.
  logic            s2_v_r;
  cnalu_pkg::op_t  s2_op_r;
  logic            s2_dz_r;
  logic [DW-1:0]   s2_rr_r, s2_ri_r;
  logic            s2_neg_re_r, s2_neg_im_r;
  logic [PW-1:0]   s2_m_re_r, s2_m_im_r, s2_den_r;
  logic signed [WW-1:0] mul_re, mul_im, div_re, div_im;
  logic [WW-1:0]   abs_re, abs_im;
  logic [DW-1:0]   s2_rr_nxt, s2_ri_nxt;

  // Stage 3 onward: overflow check and the iteration chain.
  cnalu_pkg::iter_t prep;
  cnalu_pkg::iter_t ch_d [STEPS+1];
  logic             ch_v [STEPS+1];
  logic             s3_v_r;
  cnalu_pkg::iter_t s3_r;

  // Output register.
  logic            out_valid_r;
  logic [DW-1:0]   out_re_r, out_im_r, out_mag_r;
  logic            out_dz_r;
  logic [DW-1:0]   fin_re, fin_im, fin_mag;
  logic            fin_dz;
  cnalu_pkg::iter_t fd;

  // The whole pipeline advances while the output register can take a transfer.
  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && q_avail;

  assign p_rr = $signed(q_data.a_re) * $signed(q_data.b_re);
  assign p_ii = $signed(q_data.a_im) * $signed(q_data.b_im);
  assign p_ri = $signed(q_data.a_re) * $signed(q_data.b_im);
  assign p_ir = $signed(q_data.a_im) * $signed(q_data.b_re);
  assign sq_r = $signed(q_data.b_re) * $signed(q_data.b_re);
  assign sq_i = $signed(q_data.b_im) * $signed(q_data.b_im);

  always_comb begin
    s1_rr_nxt = '0;
    s1_ri_nxt = '0;
    case (q_data.op)
      cnalu_pkg::OP_ADD: begin
        s1_rr_nxt = cnalu_pkg::sat(cnalu_pkg::ext_d(q_data.a_re) + cnalu_pkg::ext_d(q_data.b_re));
        s1_ri_nxt = cnalu_pkg::sat(cnalu_pkg::ext_d(q_data.a_im) + cnalu_pkg::ext_d(q_data.b_im));
      end
      cnalu_pkg::OP_SUB: begin
        s1_rr_nxt = cnalu_pkg::sat(cnalu_pkg::ext_d(q_data.a_re) - cnalu_pkg::ext_d(q_data.b_re));
        s1_ri_nxt = cnalu_pkg::sat(cnalu_pkg::ext_d(q_data.a_im) - cnalu_pkg::ext_d(q_data.b_im));
      end
      cnalu_pkg::OP_MOD: begin
        s1_rr_nxt = q_data.a_re;
        s1_ri_nxt = cnalu_pkg::sat(-cnalu_pkg::ext_d(q_data.a_im));
      end
      default: begin
        s1_rr_nxt = '0;
        s1_ri_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r   <= q_data.op;
      s1_dz_r   <= q_data.dz;
      s1_p_rr_r <= p_rr;
      s1_p_ii_r <= p_ii;
      s1_p_ri_r <= p_ri;
      s1_p_ir_r <= p_ir;
      s1_sq_r_r <= sq_r;
      s1_sq_i_r <= sq_i;
      s1_rr_r   <= s1_rr_nxt;
      s1_ri_r   <= s1_ri_nxt;
    end
  end

  // Multiply sums are floored by the fraction shift; divide sums become sign and size.
  always_comb begin
    mul_re = cnalu_pkg::ext_p(s1_p_rr_r) - cnalu_pkg::ext_p(s1_p_ii_r);
    mul_im = cnalu_pkg::ext_p(s1_p_ri_r) + cnalu_pkg::ext_p(s1_p_ir_r);
    div_re = cnalu_pkg::ext_p(s1_p_rr_r) + cnalu_pkg::ext_p(s1_p_ii_r);
    div_im = cnalu_pkg::ext_p(s1_p_ir_r) - cnalu_pkg::ext_p(s1_p_ri_r);
    abs_re = div_re[WW-1] ? WW'(-div_re) : WW'(div_re);
    abs_im = div_im[WW-1] ? WW'(-div_im) : WW'(div_im);
    if (s1_op_r == cnalu_pkg::OP_MUL) begin
      s2_rr_nxt = cnalu_pkg::sat(mul_re >>> FB);
      s2_ri_nxt = cnalu_pkg::sat(mul_im >>> FB);
    end else begin
      s2_rr_nxt = s1_rr_r;
      s2_ri_nxt = s1_ri_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op_r     <= s1_op_r;
      s2_dz_r     <= s1_dz_r;
      s2_rr_r     <= s2_rr_nxt;
      s2_ri_r     <= s2_ri_nxt;
      s2_neg_re_r <= div_re[WW-1];
      s2_neg_im_r <= div_im[WW-1];
      s2_m_re_r   <= abs_re[PW-1:0];
      s2_m_im_r   <= abs_im[PW-1:0];
      s2_den_r    <= s1_sq_r_r + s1_sq_i_r;
    end
  end

  // Quotients of a full word or more saturate; the rest run through the chain.
  always_comb begin
    prep.op      = s2_op_r;
    prep.dz      = s2_dz_r;
    prep.rr      = s2_rr_r;
    prep.ri      = s2_ri_r;
    prep.neg_re  = s2_neg_re_r;
    prep.neg_im  = s2_neg_im_r;
    prep.ovf_re  = ({{SH{1'b0}}, s2_m_re_r} >= {s2_den_r, {SH{1'b0}}});
    prep.ovf_im  = ({{SH{1'b0}}, s2_m_im_r} >= {s2_den_r, {SH{1'b0}}});
    prep.den     = s2_den_r;
    prep.drem_re = {{SH{1'b0}}, s2_m_re_r[PW-1:SH]};
    prep.drem_im = {{SH{1'b0}}, s2_m_im_r[PW-1:SH]};
    prep.dlo_re  = {s2_m_re_r[SH-1:0], {FB{1'b0}}};
    prep.dlo_im  = {s2_m_im_r[SH-1:0], {FB{1'b0}}};
    prep.q_re    = '0;
    prep.q_im    = '0;
    prep.srem    = '0;
    prep.sn      = s2_m_re_r;
    prep.sroot   = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= prep;
    end
  end

  // Valid bits of the first three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= q_avail;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  assign ch_v[0] = s3_v_r;
  assign ch_d[0] = s3_r;

  // One quotient bit for each part and one root bit per stage.
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    cnalu_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_v  (ch_v[k]),
      .in_d  (ch_d[k]),
      .out_v (ch_v[k+1]),
      .out_d (ch_d[k+1])
    );
  end

  // Final selection and saturation of the quotients.
  always_comb begin
    fd      = ch_d[STEPS];
    fin_re  = fd.rr;
    fin_im  = fd.ri;
    fin_mag = '0;
    fin_dz  = 1'b0;
    case (fd.op)
      cnalu_pkg::OP_DIV: begin
        fin_dz = fd.dz;
        if (fd.dz) begin
          fin_re = '0;
          fin_im = '0;
        end else begin
          if (fd.ovf_re || fd.q_re[DW-1]) begin
            fin_re = fd.neg_re ? cnalu_pkg::SMIN_V : cnalu_pkg::SMAX_V;
          end else begin
            fin_re = fd.neg_re ? DW'(-fd.q_re) : fd.q_re;
          end
          if (fd.ovf_im || fd.q_im[DW-1]) begin
            fin_im = fd.neg_im ? cnalu_pkg::SMIN_V : cnalu_pkg::SMAX_V;
          end else begin
            fin_im = fd.neg_im ? DW'(-fd.q_im) : fd.q_im;
          end
        end
      end
      cnalu_pkg::OP_MOD: fin_mag = fd.sroot;
      default: fin_mag = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ch_v[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_re_r  <= fin_re;
      out_im_r  <= fin_im;
      out_mag_r <= fin_mag;
      out_dz_r  <= fin_dz;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_res_re      = out_re_r;
  assign out_res_im      = out_im_r;
  assign out_magnitude   = out_mag_r;
  assign out_div_by_zero = out_dz_r;

  `CNA_ASSERT_IMPL(a_dz_zero_result, out_valid_r && out_dz_r, (out_re_r == '0) && (out_im_r == '0) && (out_mag_r == '0))

endmodule

`default_nettype wire

### rtl/complex_number_alu_unit.sv
// Complex arithmetic unit, signed Q16.16 operands and results.
// Throughput: one item per cycle while out_stall is low; the divider and square root
// chain has 32 stages and is fully pipelined.
// A four entry queue separates the decode front end from the arithmetic pipeline.
// Reset (rst_n low, synchronous) empties the queue and all pipeline valid bits.
`timescale 1ns / 1ps
`default_nettype none

module complex_number_alu_unit #(
  parameter int FIFO_DEPTH = cnalu_pkg::FIFO_DEPTH
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire  [2:0]                 in_cmd,
  input  wire  [cnalu_pkg::DW-1:0]   in_a_re,
  input  wire  [cnalu_pkg::DW-1:0]   in_a_im,
  input  wire  [cnalu_pkg::DW-1:0]   in_b_re,
  input  wire  [cnalu_pkg::DW-1:0]   in_b_im,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [cnalu_pkg::DW-1:0]   out_res_re,
  output logic [cnalu_pkg::DW-1:0]   out_res_im,
  output logic [cnalu_pkg::DW-1:0]   out_magnitude,
  output logic                       out_div_by_zero
);

  logic             push, full, pop, avail;
  cnalu_pkg::item_t push_data, pop_data;

  // Decode and hold one item.
  cnalu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_a_re   (in_a_re),
    .in_a_im   (in_a_im),
    .in_b_re   (in_b_re),
    .in_b_im   (in_b_im),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // Queue between decode and arithmetic.
  cnalu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .avail     (avail),
    .pop_data  (pop_data)
  );

  // Arithmetic pipeline and output register.
  cnalu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_avail         (avail),
    .q_data          (pop_data),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_res_re      (out_res_re),
    .out_res_im      (out_res_im),
    .out_magnitude   (out_magnitude),
    .out_div_by_zero (out_div_by_zero)
  );

endmodule

`default_nettype wire

### tb/sv/complex_number_alu_unit_tb.sv
`timescale 1ns / 1ps

module complex_number_alu_unit_tb;
  import cnalu_pkg::*;

  localparam int LATENCY = 37;

  typedef struct {
    logic [2:0]    cmd;
    logic [DW-1:0] a_re;
    logic [DW-1:0] a_im;
    logic [DW-1:0] b_re;
    logic [DW-1:0] b_im;
  } operands_t;

  typedef struct {
    logic [DW-1:0] res_re;
    logic [DW-1:0] res_im;
    logic [DW-1:0] magnitude;
    logic          div_by_zero;
  } answer_t;

  // One row of the directed table; known is set when the answer is typed in.
  typedef struct {
    operands_t ops;
    bit        known;
    answer_t   ans;
  } vector_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [2:0] in_cmd;
  logic [DW-1:0] in_a_re, in_a_im, in_b_re, in_b_im;
  logic out_valid;
  logic out_stall;
  logic [DW-1:0] out_res_re, out_res_im, out_magnitude;
  logic out_div_by_zero;

  answer_t pending_answers[$];
  int errors;
  bit calm;

  complex_number_alu_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_a_re(in_a_re), .in_a_im(in_a_im), .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_res_re(out_res_re), .out_res_im(out_res_im),
    .out_magnitude(out_magnitude), .out_div_by_zero(out_div_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // Clamp a wide signed value to the data range.
  function automatic logic [DW-1:0] clamp(input logic signed [127:0] v);
    if (v > 128'sh7fffffff) return SMAX_V;
    if (v < -128'sh80000000) return SMIN_V;
    return v[DW-1:0];
  endfunction

  // Quotient of a scaled numerator, truncated toward zero, then clamped.
  function automatic logic [DW-1:0] div_trunc(input logic signed [127:0] num,
                                              input logic signed [127:0] den);
    logic signed [127:0] q;
    q = (num <<< FB) / den;
    return clamp(q);
  endfunction

  // Bitwise integer square root.
  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Expected complex result for one operand set.
  function automatic answer_t complex_result(input operands_t o);
    answer_t r;
    logic signed [127:0] ar, ai, br, bi, den;
    ar = $signed(o.a_re);
    ai = $signed(o.a_im);
    br = $signed(o.b_re);
    bi = $signed(o.b_im);
    r = '{default: '0};
    if (o.cmd == CMD_SQR) begin
      br = ar;
      bi = ai;
    end
    case (o.cmd)
      CMD_ADD: begin
        r.res_re = clamp(ar + br);
        r.res_im = clamp(ai + bi);
      end
      CMD_SUB: begin
        r.res_re = clamp(ar - br);
        r.res_im = clamp(ai - bi);
      end
      CMD_MUL, CMD_SQR: begin
        r.res_re = clamp((ar * br - ai * bi) >>> FB);
        r.res_im = clamp((ar * bi + ai * br) >>> FB);
      end
      CMD_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          r.res_re = div_trunc(ar * br + ai * bi, den);
          r.res_im = div_trunc(ai * br - ar * bi, den);
        end
      end
      CMD_MOD: begin
        den = ar * ar + ai * ai;
        r.magnitude = root64(den[63:0]);
        r.res_re = o.a_re;
        r.res_im = clamp(-ai);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [DW-1:0] rand_part();
    case ($urandom_range(0, 5))
      0: return SMAX_V;
      1: return SMIN_V;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      4: return DW'($signed($urandom_range(0, 'h3ffff)) - 'h20000);
      default: return $urandom;
    endcase
  endfunction

  // Present one transfer and hold it until accepted.
  task automatic send(input operands_t o);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= o.cmd;
    in_a_re <= o.a_re;
    in_a_im <= o.a_im;
    in_b_re <= o.b_re;
    in_b_im <= o.b_im;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Result checker and output stall generator.
  always @(posedge clk) begin
    answer_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          e = pending_answers.pop_front();
          if (out_res_re !== e.res_re) begin
            $error("res_re expected %h actual %h", e.res_re, out_res_re);
            errors++;
          end
          if (out_res_im !== e.res_im) begin
            $error("res_im expected %h actual %h", e.res_im, out_res_im);
            errors++;
          end
          if (out_magnitude !== e.magnitude) begin
            $error("magnitude expected %h actual %h", e.magnitude, out_magnitude);
            errors++;
          end
          if (out_div_by_zero !== e.div_by_zero) begin
            $error("div_by_zero expected %b actual %b", e.div_by_zero, out_div_by_zero);
            errors++;
          end
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 10);
    end
  end

  initial begin
    vector_t table_rows[$];
    operands_t o;
    answer_t z;
    int n;
    errors = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = '0;
    in_a_re = '0;
    in_a_im = '0;
    in_b_re = '0;
    in_b_im = '0;
    out_stall = 1'b0;
    z = '{default: '0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: extremes, every code, zero divisor, negated minimum.
    table_rows.push_back('{'{CMD_ADD, SMAX_V, SMIN_V, 32'd1, 32'hffffffff}, 1'b1,
                           '{SMAX_V, SMIN_V, 32'd0, 1'b0}});
    table_rows.push_back('{'{CMD_SUB, SMIN_V, SMAX_V, 32'd1, 32'hffffffff}, 1'b1,
                           '{SMIN_V, SMAX_V, 32'd0, 1'b0}});
    table_rows.push_back('{'{CMD_DIV, 32'h12345, SMIN_V, 32'd0, 32'd0}, 1'b1,
                           '{32'd0, 32'd0, 32'd0, 1'b1}});
    table_rows.push_back('{'{CMD_MOD, 32'd0, SMIN_V, 32'd0, 32'd0}, 1'b1,
                           '{32'd0, SMAX_V, 32'h8000_0000, 1'b0}});
    table_rows.push_back('{'{3'd6, SMAX_V, SMAX_V, SMAX_V, SMAX_V}, 1'b1, z});
    table_rows.push_back('{'{3'd7, SMIN_V, SMIN_V, SMIN_V, SMIN_V}, 1'b1, z});
    table_rows.push_back('{'{CMD_MUL, SMIN_V, SMIN_V, SMIN_V, SMIN_V}, 1'b0, z});
    table_rows.push_back('{'{CMD_MUL, SMAX_V, SMIN_V, SMAX_V, SMAX_V}, 1'b0, z});
    table_rows.push_back('{'{CMD_MUL, 32'h10000, 32'hffff8000, 32'hfffe8000, 32'h3}, 1'b0, z});
    table_rows.push_back('{'{CMD_SQR, SMIN_V, SMIN_V, 32'd0, 32'd0}, 1'b0, z});
    table_rows.push_back('{'{CMD_SQR, 32'h18000, 32'hffff0000, 32'd0, 32'd0}, 1'b0, z});
    table_rows.push_back('{'{CMD_DIV, SMAX_V, SMAX_V, 32'd1, 32'd0}, 1'b0, z});
    table_rows.push_back('{'{CMD_DIV, SMIN_V, SMIN_V, 32'd0, 32'hffffffff}, 1'b0, z});
    table_rows.push_back('{'{CMD_DIV, 32'h10000, 32'hfffeffff, 32'h30000, 32'hffff0000}, 1'b0, z});
    table_rows.push_back('{'{CMD_DIV, SMIN_V, SMAX_V, SMIN_V, SMIN_V}, 1'b0, z});
    table_rows.push_back('{'{CMD_MOD, SMIN_V, SMIN_V, 32'd0, 32'd0}, 1'b0, z});
    table_rows.push_back('{'{CMD_MOD, SMAX_V, 32'h30000, 32'd0, 32'd0}, 1'b0, z});
    foreach (table_rows[i]) begin
      pending_answers.push_back(table_rows[i].known ? table_rows[i].ans
                                                    : complex_result(table_rows[i].ops));
      send(table_rows[i].ops);
    end

    // Hold off until every result of the directed part has come back.
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);

    // Random part, with a stretch free of idling on both sides.
    for (n = 0; n < 800; n++) begin
      calm = (n >= 300 && n < 420);
      o.cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
      o.a_re = rand_part();
      o.a_im = rand_part();
      o.b_re = rand_part();
      o.b_im = rand_part();
      pending_answers.push_back(complex_result(o));
      send(o);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
